// ===== src/bfs_pkg.sv =====
// ---------------------------------------------------------------------------
// bfs_pkg
// Shared constants and types for the byte to float scale block.
// ---------------------------------------------------------------------------
package bfs_pkg;

	localparam int LANES_DEFAULT = 4;
	localparam int PORT_LANES    = 4;

	localparam logic [31:0] SCALE_RESET = 32'h3F80_0000;
	localparam logic [31:0] QNAN_DEFAULT = 32'h7FC0_0000;
	localparam logic [31:0] QUIET_BIT    = 32'h0040_0000;

	typedef logic [7:0]  byte_t;
	typedef logic [31:0] word_t;
	typedef logic [2:0]  count_t;

endpackage

// ===== src/bfs_lane.sv =====
// ---------------------------------------------------------------------------
// bfs_lane
// One lane: unsigned byte times single-precision scale, rounded to nearest
// even. Multiply in the first stage, normalise and round after it.
// ---------------------------------------------------------------------------
module bfs_lane (
	input  logic          clk,
	input  logic          load,
	input  bfs_pkg::byte_t in_byte,
	input  bfs_pkg::word_t scale,
	output bfs_pkg::word_t result
);
	import bfs_pkg::*;

	logic [7:0]  ex;
	logic [22:0] man;
	logic [23:0] mant;
	logic [8:0]  e;
	logic [31:0] p_s1;
	byte_t       b_s1;

	assign ex   = scale[30:23];
	assign man  = scale[22:0];
	assign mant = {ex != 8'd0, man};
	assign e    = (ex == 8'd0) ? 9'd1 : {1'b0, ex};

	always_ff @(posedge clk) begin
		if (load) begin
			p_s1 <= {8'd0, mant} * {24'd0, in_byte};
			b_s1 <= in_byte;
		end
	end

	logic [4:0]         k;
	logic signed [10:0] sh_top, sh_sub, shift, biased;
	logic [3:0]         rsh;
	logic [4:0]         lsh;
	logic [31:0]        q, rem, half, mask;
	logic               rnd, carry;

	always_comb begin
		k = 5'd0;
		for (int i = 0; i < 32; i++) begin
			if (p_s1[i]) k = 5'(i);
		end
		sh_top = $signed({6'd0, k}) - 11'sd23;
		sh_sub = 11'sd1 - $signed({2'd0, e});
		shift  = (sh_sub > sh_top) ? sh_sub : sh_top;
		rsh    = shift[3:0];
		lsh    = 5'(-shift);
		mask   = 32'd0;
		half   = 32'd0;
		rem    = 32'd0;
		rnd    = 1'b0;
		if (shift > 11'sd0) begin
			mask = (32'd1 << rsh) - 32'd1;
			half = 32'd1 << (rsh - 4'd1);
			rem  = p_s1 & mask;
			q    = p_s1 >> rsh;
			rnd  = (rem > half) || ((rem == half) && q[0]);
			q    = q + {31'd0, rnd};
		end else begin
			q = p_s1 << lsh;
		end
		// rounding may carry into a new leading bit
		carry = q[24];
		if (carry) q = q >> 1;
		biased = shift + $signed({2'd0, e}) + $signed({10'd0, carry});
	end

	always_comb begin
		if (ex == 8'hFF) begin
			if (man != 23'd0) result = scale | QUIET_BIT;
			else if (b_s1 == 8'd0) result = QNAN_DEFAULT;
			else result = scale;
		end else if (b_s1 == 8'd0 || scale[30:0] == 31'd0) begin
			result = {scale[31], 31'd0};
		end else if (!q[23]) begin
			result = {scale[31], 8'd0, q[22:0]};
		end else if (biased >= 11'sd255) begin
			result = {scale[31], 8'hFF, 23'd0};
		end else begin
			result = {scale[31], biased[7:0], q[22:0]};
		end
	end

endmodule

// ===== src/byte_to_float_scale.sv =====
// ---------------------------------------------------------------------------
// byte_to_float_scale
// Four byte lanes converted to single precision and scaled by a register.
// ---------------------------------------------------------------------------
// Takes one beat per cycle while in_stall is low: a multiply stage in each
// lane, then a normalise and round stage that the output register closes,
// where lanes are merged and invalid ones zeroed. The user must write the
// scale (reset 1.0) through cfg_we/cfg_data while idle (not enforced).
module byte_to_float_scale #(
	parameter int LANES = bfs_pkg::LANES_DEFAULT
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  bfs_pkg::word_t  cfg_data,
	input  logic            in_valid,
	output logic            in_stall,
	input  bfs_pkg::byte_t  byte_a,
	input  bfs_pkg::byte_t  byte_b,
	input  bfs_pkg::byte_t  byte_c,
	input  bfs_pkg::byte_t  byte_d,
	input  bfs_pkg::count_t valid_count,
	input  logic            end_of_buffer,
	output logic            out_valid,
	input  logic            out_stall,
	output bfs_pkg::word_t  result_a,
	output bfs_pkg::word_t  result_b,
	output bfs_pkg::word_t  result_c,
	output bfs_pkg::word_t  result_d,
	output bfs_pkg::count_t result_count,
	output logic            result_last
);
	import bfs_pkg::*;

	word_t  scale_q;
	logic   vld_s1, vld_s2, go_s1, go_s2;
	count_t cnt_s1, cnt_s2;
	logic   last_s1, last_s2;
	byte_t  bytes [PORT_LANES];
	word_t  lane_res [PORT_LANES];
	word_t  res_s2 [PORT_LANES];

	assign bytes[0] = byte_a;
	assign bytes[1] = byte_b;
	assign bytes[2] = byte_c;
	assign bytes[3] = byte_d;

	assign go_s2    = vld_s1 && (!vld_s2 || !out_stall);
	assign in_stall = vld_s1 && vld_s2 && out_stall;
	assign go_s1    = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_RESET;
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
		end else begin
			if (cfg_we) scale_q <= cfg_data;
			if (go_s1) vld_s1 <= 1'b1;
			else if (go_s2) vld_s1 <= 1'b0;
			if (go_s2) vld_s2 <= 1'b1;
			else if (!out_stall) vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1) begin
			cnt_s1  <= valid_count;
			last_s1 <= end_of_buffer;
		end
		if (go_s2) begin
			cnt_s2  <= cnt_s1;
			last_s2 <= last_s1;
		end
	end

	for (genvar i = 0; i < PORT_LANES; i++) begin : g_lane
		if (i < LANES) begin : g_on
			bfs_lane u_lane (
				.clk     (clk),
				.load    (go_s1),
				.in_byte (bytes[i]),
				.scale   (scale_q),
				.result  (lane_res[i])
			);
		end else begin : g_off
			assign lane_res[i] = '0;
		end
		// merge: lanes at or above the count give zero
		always_ff @(posedge clk) begin
			if (go_s2) begin
				res_s2[i] <= ({1'b0, cnt_s1} > 4'(i)) ? lane_res[i] : '0;
			end
		end
	end

	assign out_valid    = vld_s2;
	assign result_a     = res_s2[0];
	assign result_b     = res_s2[1];
	assign result_c     = res_s2[2];
	assign result_d     = res_s2[3];
	assign result_count = cnt_s2;
	assign result_last  = last_s2;

endmodule

// ===== src/bfs_checker.sv =====
// ---------------------------------------------------------------------------
// bfs_checker
// Port-level checks for byte_to_float_scale, bound to the top level.
// ---------------------------------------------------------------------------
module bfs_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            out_valid,
	input logic            out_stall,
	input bfs_pkg::word_t  result_b,
	input bfs_pkg::word_t  result_c,
	input bfs_pkg::word_t  result_d,
	input bfs_pkg::count_t result_count
);
	import bfs_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result beat dropped under stall");

	a_lane_b: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_count < 3'd2 |-> result_b == '0)
		else $error("invalid lane b not zero");

	a_lane_c: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_count < 3'd3 |-> result_c == '0)
		else $error("invalid lane c not zero");

	a_lane_d: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_count < 3'd4 |-> result_d == '0)
		else $error("invalid lane d not zero");

endmodule

bind byte_to_float_scale bfs_checker u_bfs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.result_b     (result_b),
	.result_c     (result_c),
	.result_d     (result_d),
	.result_count (result_count)
);

// ===== tb/byte_to_float_scale_tb.sv =====
// ---------------------------------------------------------------------------
// byte_to_float_scale_tb
// Self-checking bench: directed and random byte groups scaled by a range of
// scale values, whole beats compared against an integer-only product predictor.
// ---------------------------------------------------------------------------
module byte_to_float_scale_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import bfs_pkg::*;

	typedef struct packed {
		byte_t  a, b, c, d;
		count_t cnt;
		logic   last;
	} group_t;

	typedef struct packed {
		word_t  ra, rb, rc, rd;
		count_t cnt;
		logic   last;
	} scaled_t;

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   cfg_we = 1'b0;
	word_t  cfg_data = '0;
	logic   in_valid = 1'b0;
	logic   in_stall;
	byte_t  byte_a = '0, byte_b = '0, byte_c = '0, byte_d = '0;
	count_t valid_count = '0;
	logic   end_of_buffer = 1'b0;
	logic   out_valid;
	logic   out_stall = 1'b0;
	word_t  result_a, result_b, result_c, result_d;
	count_t result_count;
	logic   result_last;

	byte_to_float_scale dut (
		.clk, .arst_n, .cfg_we, .cfg_data,
		.in_valid, .in_stall, .byte_a, .byte_b, .byte_c, .byte_d,
		.valid_count, .end_of_buffer,
		.out_valid, .out_stall, .result_a, .result_b, .result_c, .result_d,
		.result_count, .result_last
	);

	always #5 clk = ~clk;

	group_t  pending_q[$];
	scaled_t expected_q[$];
	word_t   scale_reg = SCALE_RESET;
	int      mismatches = 0;
	int      idle_cycles = 0;
	int      send_gap = 0;
	int      recv_gap = 0;
	bit      hold_send = 1'b0;
	bit      in_taken = 1'b0;

	// exact byte times scale, one round to nearest even, subnormals kept
	function automatic word_t scale_byte(input byte_t b, input word_t s);
		logic        sgn;
		logic [7:0]  ex;
		logic [23:0] mant;
		logic [63:0] p, q, rem, half;
		int          e, k, sh, sub_sh, biased;
		sgn = s[31];
		ex = s[30:23];
		mant = {1'b0, s[22:0]};
		if (ex == 8'hFF) begin
			if (s[22:0] != 0) return s | QUIET_BIT;
			return (b == 0) ? QNAN_DEFAULT : s;
		end
		if (b == 0 || s[30:0] == 0) return {sgn, 31'b0};
		if (ex == 0) begin
			e = 1;
		end else begin
			e = int'(ex);
			mant[23] = 1'b1;
		end
		p = 64'(b) * 64'(mant);
		k = 0;
		while (k < 63 && (p >> (k + 1)) != 0) k++;
		sh = k - 23;
		sub_sh = -149 - (e - 150);
		if (sub_sh > sh) sh = sub_sh;
		if (sh > 0) begin
			q = p >> sh;
			rem = p & ((64'd1 << sh) - 1);
			half = 64'd1 << (sh - 1);
			if (rem > half || (rem == half && q[0])) q++;
		end else begin
			q = p << (-sh);
		end
		sh += e - 150;
		if (q >= (64'd1 << 24)) begin
			q >>= 1;
			sh++;
		end
		if (q < (64'd1 << 23)) return {sgn, q[30:0]};
		biased = sh + 150;
		if (biased >= 255) return {sgn, 31'h7F80_0000};
		return {sgn, 8'(biased), q[22:0]};
	endfunction

	function automatic scaled_t predict_group(input group_t g);
		scaled_t r;
		r.ra = (0 < g.cnt) ? scale_byte(g.a, scale_reg) : '0;
		r.rb = (1 < g.cnt) ? scale_byte(g.b, scale_reg) : '0;
		r.rc = (2 < g.cnt) ? scale_byte(g.c, scale_reg) : '0;
		r.rd = (3 < g.cnt) ? scale_byte(g.d, scale_reg) : '0;
		r.cnt = g.cnt;
		r.last = g.last;
		return r;
	endfunction

	function automatic group_t rand_group();
		group_t g;
		g = 36'({$urandom, $urandom});
		g.cnt = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7))
			: 3'($urandom_range(1, 4));
		return g;
	endfunction

	// driver: beat pops from the pending queue, prediction made on acceptance
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_taken) begin
				expected_q.push_back(predict_group(pending_q.pop_front()));
				send_gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 16) : 0;
			end
			if (in_valid && !in_taken) begin
				// payload held
			end else if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (pending_q.size() > 0 && !hold_send) begin
				in_valid <= 1'b1;
				{byte_a, byte_b, byte_c, byte_d, valid_count, end_of_buffer}
					<= pending_q[0];
			end else begin
				in_valid <= 1'b0;
			end
			if (recv_gap > 0) begin
				recv_gap--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		scaled_t got, exp_r;
		if (arst_n) begin
			idle_cycles++;
			in_taken = in_valid && !in_stall;
			if (in_taken) idle_cycles = 0;
			if (out_valid && !out_stall) begin
				idle_cycles = 0;
				got = {result_a, result_b, result_c, result_d, result_count, result_last};
				if (expected_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected beat %h", got);
				end else begin
					exp_r = expected_q.pop_front();
					if (got !== exp_r) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch scale %h exp %h got %h", scale_reg, exp_r, got);
					end
				end
				recv_gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 16) : 0;
			end
			if (idle_cycles > 2000) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	task automatic drain();
		while (pending_q.size() > 0 || expected_q.size() > 0 || in_valid)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_scale(input word_t v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		scale_reg = v;
	endtask

	initial begin
		word_t  scales[$];
		group_t g;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed groups at reset scale
		pending_q.push_back({8'd0, 8'd1, 8'd128, 8'd255, 3'd4, 1'b0});
		pending_q.push_back({8'd255, 8'd255, 8'd255, 8'd255, 3'd4, 1'b1});
		pending_q.push_back({8'd7, 8'd9, 8'd11, 8'd13, 3'd0, 1'b0});
		pending_q.push_back({8'd7, 8'd9, 8'd11, 8'd13, 3'd1, 1'b0});
		pending_q.push_back({8'd7, 8'd9, 8'd11, 8'd13, 3'd7, 1'b1});
		pending_q.push_back({8'd7, 8'd9, 8'd11, 8'd13, 3'd5, 1'b0});
		drain();

		// extremes: zeros, infinities, nans, subnormals, max, negative, rounding
		scales = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
			32'h7F80_0001, 32'hFFC0_1234, 32'h0000_0001, 32'h807F_FFFF,
			32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h3F80_0001, 32'hFFFF_FFFF,
			32'h0080_0000, 32'h3EAA_AAAB};
		foreach (scales[i]) begin
			write_scale(scales[i]);
			pending_q.push_back({8'd0, 8'd1, 8'd3, 8'd255, 3'd4, 1'b0});
			pending_q.push_back({8'd254, 8'd127, 8'd85, 8'd2, 3'($urandom_range(0, 7)), 1'b1});
			drain();
		end

		// random phases, each with its own scale
		for (int ph = 0; ph < 16; ph++) begin
			case ($urandom_range(0, 3))
				0: write_scale($urandom);
				1: write_scale({1'($urandom), 8'($urandom_range(0, 3)), 23'($urandom)});
				2: write_scale({1'($urandom), 8'($urandom_range(240, 254)), 23'($urandom)});
				default: write_scale({1'($urandom), 8'($urandom_range(100, 150)), 23'($urandom)});
			endcase
			for (int n = 0; n < 100; n++) begin
				g = rand_group();
				pending_q.push_back(g);
			end
			if (ph == 8) begin
				// sender holds off until the pipeline has emptied
				while (pending_q.size() > 50) @(posedge clk);
				hold_send = 1'b1;
				while (expected_q.size() > 0 || in_valid) @(posedge clk);
				hold_send = 1'b0;
			end
			drain();
		end
		write_scale(SCALE_RESET);

		if (mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule

// ===== filelist.f =====
src/bfs_pkg.sv
src/bfs_lane.sv
src/byte_to_float_scale.sv
src/bfs_checker.sv
tb/byte_to_float_scale_tb.sv
